@@ rtl/core/nbc_pkg.sv @@
package nbc_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int VALUE_BITS_DEF  = 16;
  localparam int AXES            = 4;
  localparam int INDEX_BITS      = 6;
  localparam int COUNT_BITS      = 7;
  localparam int DIST_BITS       = 36;
  localparam int TIE_BITS        = 64;
  localparam int PADDR_BITS      = 3;
  localparam int PDATA_BITS      = 32;

  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Register index as seen in paddr above the byte offset.
  localparam logic REG_ENTRY_COUNT = 1'b0;
  localparam logic [COUNT_BITS-1:0] ENTRY_COUNT_RESET = 7'd1;

  typedef struct packed {
    logic clear;
    logic ex_en;
    logic sq_en;
    logic acc_en;
  } dist_ctrl_t;

endpackage

@@ rtl/core/nbc_in_if.sv @@
interface nbc_in_if #(
  parameter int VALUE_BITS = nbc_pkg::VALUE_BITS_DEF
);
  import nbc_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [INDEX_BITS-1:0]        entry_index;
  logic [1:0]                   axis;
  logic signed [VALUE_BITS-1:0] range_low;
  logic signed [VALUE_BITS-1:0] range_high;
  logic signed [VALUE_BITS-1:0] temperature;
  logic signed [VALUE_BITS-1:0] moisture;
  logic signed [VALUE_BITS-1:0] continentalness;
  logic signed [VALUE_BITS-1:0] erosion;
  logic [TIE_BITS-1:0]          tie_key;

  modport source (
    output valid, op, entry_index, axis, range_low, range_high,
           temperature, moisture, continentalness, erosion, tie_key,
    input  ready
  );

  modport sink (
    input  valid, op, entry_index, axis, range_low, range_high,
           temperature, moisture, continentalness, erosion, tie_key,
    output ready
  );

endinterface

@@ rtl/core/nbc_out_if.sv @@
interface nbc_out_if;
  import nbc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] chosen_index;
  logic [DIST_BITS-1:0]  nearest_distance;

  modport source (
    output valid, chosen_index, nearest_distance,
    input  ready
  );

  modport sink (
    input  valid, chosen_index, nearest_distance,
    output ready
  );

endinterface

@@ rtl/core/nbc_ram.sv @@
module nbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/nbc_dist.sv @@
module nbc_dist #(
  parameter int VALUE_BITS = nbc_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  nbc_pkg::dist_ctrl_t          ctrl,
  input  logic signed [VALUE_BITS-1:0] lo,
  input  logic signed [VALUE_BITS-1:0] hi,
  input  logic signed [VALUE_BITS-1:0] v,
  output logic [nbc_pkg::DIST_BITS-1:0] total
);
  import nbc_pkg::*;

  localparam int EW = VALUE_BITS + 1;
  localparam int SW = 2 * EW;

  logic [VALUE_BITS:0]  dlo;
  logic [VALUE_BITS:0]  dhi;
  logic [EW-1:0]        tlo;
  logic [EW-1:0]        thi;
  logic [EW-1:0]        ex;
  logic [SW-1:0]        sq;
  logic [DIST_BITS-1:0] sq_sat;
  logic [DIST_BITS:0]   sum;

  assign dlo = {lo[VALUE_BITS-1], lo} - {v[VALUE_BITS-1], v};
  assign dhi = {v[VALUE_BITS-1], v} - {hi[VALUE_BITS-1], hi};

  // Only a positive difference counts; both can when the range is reversed.
  assign tlo = (!dlo[VALUE_BITS] && dlo != '0) ? {1'b0, dlo[VALUE_BITS-1:0]} : '0;
  assign thi = (!dhi[VALUE_BITS] && dhi != '0) ? {1'b0, dhi[VALUE_BITS-1:0]} : '0;

  always_comb begin
    if ((sq >> DIST_BITS) != '0) begin
      sq_sat = DIST_MAX;
    end else begin
      sq_sat = DIST_BITS'(sq);
    end
  end

  assign sum = {1'b0, total} + {1'b0, sq_sat};

  always_ff @(posedge clk) begin
    if (ctrl.ex_en) begin
      ex <= tlo + thi;
    end
    if (ctrl.sq_en) begin
      sq <= SW'(ex) * SW'(ex);
    end
    if (ctrl.clear) begin
      total <= '0;
    end else if (ctrl.acc_en) begin
      total <= sum[DIST_BITS] ? DIST_MAX : sum[DIST_BITS-1:0];
    end
  end

endmodule

@@ rtl/core/nbc_mod.sv @@
module nbc_mod #(
  parameter int DIV_BITS = 7
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [nbc_pkg::TIE_BITS-1:0] dividend,
  input  logic [DIV_BITS-1:0]          divisor,
  output logic                         done,
  output logic [DIV_BITS-1:0]          remainder
);
  import nbc_pkg::*;

  localparam int CNT_BITS = $clog2(TIE_BITS + 1);

  logic [CNT_BITS-1:0] cnt;
  logic [TIE_BITS-1:0] sh;
  logic [DIV_BITS:0]   trial;

  // One quotient bit per cycle, restoring form.
  assign trial = {remainder, sh[TIE_BITS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt       <= CNT_BITS'(TIE_BITS);
        sh        <= dividend;
        remainder <= '0;
      end else if (cnt != '0) begin
        sh  <= sh << 1;
        cnt <= cnt - 1'b1;
        if (trial >= {1'b0, divisor}) begin
          remainder <= DIV_BITS'(trial - {1'b0, divisor});
        end else begin
          remainder <= trial[DIV_BITS-1:0];
        end
        if (cnt == CNT_BITS'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/core/nearest_box_classifier.sv @@
// Nearest box classifier.
// Words arrive on the item channel (valid/ready). A load word (op = 0) writes
// one axis range of one table entry in its accept cycle and gives no result.
// A query word (op = 1) scans entries 0 .. n-1, n being entry_count clamped
// to 1 .. MAX_ENTRIES, and returns one result word: the nearest entry index
// and its summed squared excess, with ties resolved by tie_key mod count.
// Each entry passes through the one shared excess/square/accumulate unit
// in steps: a table read, the four axis steps and the pipeline drain. The
// tie pick is a bit-serial modulo, and a final pass reads the stored
// distances back at one entry per cycle, the registered read data being
// compared against a registered copy of its address.
// The item channel is not ready while a query runs. The result sits in an
// output register, so the next word is taken while a result waits; a query
// that finishes while the receiver stalls holds until the register frees.
// Reset empties the output register and sets entry_count to 1; the table
// holds no defined contents until loaded. Write entry_count over the APB
// port at address 0 only while the block is idle; nothing enforces this.
module nearest_box_classifier #(
  parameter int MAX_ENTRIES = nbc_pkg::MAX_ENTRIES_DEF,
  parameter int VALUE_BITS  = nbc_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  nbc_in_if.sink                         item,
  nbc_out_if.source                      result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nbc_pkg::PADDR_BITS-1:0] paddr,
  input  logic [nbc_pkg::PDATA_BITS-1:0] pwdata,
  output logic [nbc_pkg::PDATA_BITS-1:0] prdata,
  output logic                           pready
);
  import nbc_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int RW = 2 * VALUE_BITS;
  localparam logic [2:0] STEP_LAST = 3'd7;

  typedef enum logic [2:0] {
    IDLE,
    SCAN,
    MODW,
    PICK,
    FIN
  } state_t;

  state_t state;

  logic [COUNT_BITS-1:0]        entry_count;
  logic                         cfg_we;

  logic signed [VALUE_BITS-1:0] qv [AXES];
  logic [TIE_BITS-1:0]          tie_val;
  logic [CW-1:0]                n_req;
  logic [CW-1:0]                n_eff;
  logic [CW-1:0]                i;
  logic [2:0]                   step;
  logic [1:0]                   axis_sel;
  logic [DIST_BITS-1:0]         best;
  logic [CW-1:0]                ties;
  logic [CW-1:0]                pick;
  logic [CW-1:0]                j;
  logic [CW-1:0]                jd;
  logic                         dv;
  logic                         mod_start;
  logic                         mod_done;
  logic [CW-1:0]                mod_rem;
  logic [INDEX_BITS-1:0]        found_index;
  logic [INDEX_BITS-1:0]        out_index;
  logic [DIST_BITS-1:0]         out_dist;
  logic                         out_valid;

  logic                         load_we;
  logic [RW-1:0]                rd [AXES];
  dist_ctrl_t                   dctrl;
  logic [DIST_BITS-1:0]         acc;
  logic                         dist_we;
  logic [DIST_BITS-1:0]         dist_rd;
  logic                         last_entry;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[PADDR_BITS-1] == REG_ENTRY_COUNT);
  assign prdata = (paddr[PADDR_BITS-1] == REG_ENTRY_COUNT) ? PDATA_BITS'(entry_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= ENTRY_COUNT_RESET;
    end else if (cfg_we) begin
      entry_count <= pwdata[COUNT_BITS-1:0];
    end
  end

  always_comb begin
    if (entry_count == '0) begin
      n_req = CW'(1);
    end else if (int'(entry_count) > MAX_ENTRIES) begin
      n_req = CW'(MAX_ENTRIES);
    end else begin
      n_req = CW'(entry_count);
    end
  end

  // Range table, one memory per axis holding {high, low}.
  assign item.ready = (state == IDLE);
  assign load_we = item.valid && (state == IDLE) && (item.op == OP_LOAD) &&
                   (int'(item.entry_index) < MAX_ENTRIES);

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    nbc_ram #(
      .WIDTH (RW),
      .DEPTH (MAX_ENTRIES)
    ) u_range_ram (
      .clk   (clk),
      .we    (load_we && (item.axis == 2'(a))),
      .waddr (AW'(item.entry_index)),
      .wdata ({item.range_high, item.range_low}),
      .raddr (i[AW-1:0]),
      .rdata (rd[a])
    );
  end

  // Step 0 waits for the table read; steps 1-4 take the axis excess,
  // 2-5 square it, 3-6 accumulate, and step 7 sees the entry total.
  assign axis_sel     = 2'(step - 3'd1);
  assign dctrl.clear  = (state == SCAN) && (step == 3'd1);
  assign dctrl.ex_en  = (state == SCAN) && (step inside {[3'd1:3'd4]});
  assign dctrl.sq_en  = (state == SCAN) && (step inside {[3'd2:3'd5]});
  assign dctrl.acc_en = (state == SCAN) && (step inside {[3'd3:3'd6]});

  nbc_dist #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dist (
    .clk   (clk),
    .ctrl  (dctrl),
    .lo    ($signed(rd[axis_sel][VALUE_BITS-1:0])),
    .hi    ($signed(rd[axis_sel][RW-1:VALUE_BITS])),
    .v     (qv[axis_sel]),
    .total (acc)
  );

  assign dist_we    = (state == SCAN) && (step == STEP_LAST);
  assign last_entry = (i == n_eff - CW'(1));

  nbc_ram #(
    .WIDTH (DIST_BITS),
    .DEPTH (MAX_ENTRIES)
  ) u_dist_ram (
    .clk   (clk),
    .we    (dist_we),
    .waddr (i[AW-1:0]),
    .wdata (acc),
    .raddr (j[AW-1:0]),
    .rdata (dist_rd)
  );

  nbc_mod #(
    .DIV_BITS (CW)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (tie_val),
    .divisor   (ties),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  assign result.valid            = out_valid;
  assign result.chosen_index     = out_index;
  assign result.nearest_distance = out_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      mod_start <= 1'b0;
      dv        <= 1'b0;
    end else begin
      mod_start <= (state == SCAN) && (step == STEP_LAST) && last_entry;
      if (state == FIN && (!out_valid || result.ready)) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (item.valid && item.op == OP_QUERY) begin
            qv[0]   <= item.temperature;
            qv[1]   <= item.moisture;
            qv[2]   <= item.continentalness;
            qv[3]   <= item.erosion;
            tie_val <= item.tie_key;
            n_eff   <= n_req;
            i       <= '0;
            step    <= '0;
            state   <= SCAN;
          end
        end
        SCAN: begin
          step <= step + 3'd1;
          if (step == STEP_LAST) begin
            if (i == '0 || acc < best) begin
              best <= acc;
              ties <= CW'(1);
            end else if (acc == best) begin
              ties <= ties + CW'(1);
            end
            if (last_entry) begin
              state <= MODW;
            end else begin
              i <= i + CW'(1);
            end
          end
        end
        MODW: begin
          j  <= '0;
          dv <= 1'b0;
          if (mod_done) begin
            pick  <= mod_rem;
            state <= PICK;
          end
        end
        PICK: begin
          if (j != n_eff) begin
            j <= j + CW'(1);
          end
          jd <= j;
          dv <= (j != n_eff);
          if (dv && dist_rd == best) begin
            if (pick == '0) begin
              found_index <= INDEX_BITS'(jd);
              state       <= FIN;
            end else begin
              pick <= pick - CW'(1);
            end
          end
        end
        FIN: begin
          // The output register may still hold an earlier word.
          if (!out_valid || result.ready) begin
            out_index <= found_index;
            out_dist  <= best;
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_query_blocks: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready && item.op == OP_QUERY) |=> !item.ready)
    else $error("item channel ready right after a query was taken");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == SCAN) |-> (i < n_eff))
    else $error("scan index ran past the entry count");

  a_ties_valid: assert property (@(posedge clk) disable iff (rst)
    (state == MODW) |-> (ties != '0 && ties <= n_eff))
    else $error("tie count out of range during modulo");

  a_pick_below_ties: assert property (@(posedge clk) disable iff (rst)
    (state == PICK) |-> (pick < ties))
    else $error("tie pick not below tie count");

endmodule
